// ----- rtl/core/mlf_pkg.sv -----
// Marker line framer: shared types, codes and character constants.
// No dependencies; used by the command queue, classifier, emitter, top level and testbench.
`timescale 1ns / 1ps

package mlf_pkg;

    // Widest line length field a command can carry (line store depth up to 63).
    localparam int CMD_LEN_W = 6;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_9  = 8'h39;

    // Result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_MARK  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER_TEXT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER_LEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_TEXT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_LEN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_EN      = 3'd4;

    typedef enum logic {
        OP_LINE,
        OP_MARK
    } t_op;

    // Work handed from the classifier to the emitter.
    typedef struct packed {
        t_op                  op;
        logic [CMD_LEN_W-1:0] len;
        logic                 ovf;
    } t_cmd;

endpackage

// ----- rtl/core/mlf_in_if.sv -----
// Input byte channel of the marker line framer.
// Depends on nothing.
`timescale 1ns / 1ps

interface mlf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- rtl/core/mlf_out_if.sv -----
// Result channel of the marker line framer.
// Depends on nothing.
`timescale 1ns / 1ps

interface mlf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] frame_byte;
    logic       frame_last;
    logic       truncated;

    modport source (output valid, output kind, output frame_byte, output frame_last,
                    output truncated, input ready);
    modport sink   (input valid, input kind, input frame_byte, input frame_last,
                    input truncated, output ready);
endinterface

// ----- rtl/core/mlf_ram.sv -----
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/mlf_cmd_q.sv -----
// Two-entry command queue between the classifier and the emitter.
// Depends on mlf_pkg.
`timescale 1ns / 1ps

module mlf_cmd_q (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mlf_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_vld,
    output mlf_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    mlf_pkg::t_cmd r_ent [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_cnt;
    logic          do_push;
    logic          do_pop;

    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_vld   = (r_cnt != 2'd0);
    assign o_cmd   = r_ent[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wptr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_cnt != 2'd2)
        else $error("command pushed into full queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("queue count lost a push");

endmodule

// ----- rtl/core/mlf_front.sv -----
// Classifier: takes input beats, tracks line, marker and token state, writes
// the line store and queues emission commands. Depends on mlf_pkg, mlf_in_if.
`timescale 1ns / 1ps

module mlf_front #(
    parameter int LINE_DEPTH   = 63,
    parameter int MARKER_BYTES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mlf_in_if.sink                            i_in,
    input  logic                              i_cfg_we,
    input  logic [mlf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [63:0]                       i_cfg_data,
    output logic                              o_ram_we,
    output logic [$clog2(LINE_DEPTH)-1:0]     o_ram_waddr,
    output logic [7:0]                        o_ram_wdata,
    output logic                              o_push,
    output mlf_pkg::t_cmd                     o_cmd,
    input  logic                              i_q_full,
    input  logic                              i_release
);

    localparam int LEN_W  = $clog2(LINE_DEPTH + 1);
    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int WIN_W  = 8 * MARKER_BYTES;

    typedef enum logic [1:0] {
        M_NORMAL,
        M_TOKEN,
        M_AFTER_CR
    } t_mode;

    // configuration
    logic [WIN_W-1:0] r_mtext;
    logic [3:0]       r_mlen;
    logic [63:0]      r_etext;
    logic [3:0]       r_elen;
    logic             r_een;

    // parse state
    logic             r_slot_vld;
    logic [7:0]       r_slot_byte;
    logic             r_busy;
    t_mode            r_mode;
    logic [LEN_W-1:0] r_len;
    logic [WIN_W-1:0] r_win;
    logic [3:0]       r_cnt;
    logic             r_eq;
    logic             r_ovf;

    t_mode            n_mode;
    logic [LEN_W-1:0] n_len;
    logic [WIN_W-1:0] n_win;
    logic [3:0]       n_cnt;
    logic             n_eq;
    logic             n_ovf;
    logic             consume;
    logic             work;

    logic [WIN_W-1:0] win_new;
    logic             hit;
    logic [3:0]       drop;
    logic [3:0]       idx;
    logic [7:0]       b;
    logic             is_digit;

    assign b        = r_slot_byte;
    assign work     = r_slot_vld && !r_busy && !i_q_full;
    assign win_new  = (r_win << 8) | WIN_W'(b);
    assign drop     = r_mlen - 4'd1;
    assign idx      = r_elen - 4'd1 - r_cnt;
    assign is_digit = (b >= mlf_pkg::CHAR_0) && (b <= mlf_pkg::CHAR_9);

    always_comb begin
        hit = (r_mlen != 4'd0) && (r_mlen <= 4'(MARKER_BYTES))
              && (r_ovf || (7'(r_len) + 7'd1 >= 7'(r_mlen)));
        for (int i = 0; i < MARKER_BYTES; i++) begin
            if ((4'(i) < r_mlen) && (win_new[8*i +: 8] != r_mtext[8*i +: 8])) begin
                hit = 1'b0;
            end
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_len       = r_len;
        n_win       = r_win;
        n_cnt       = r_cnt;
        n_eq        = r_eq;
        n_ovf       = r_ovf;
        consume     = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_len[ADDR_W-1:0];
        o_ram_wdata = b;
        o_push      = 1'b0;
        o_cmd.op    = mlf_pkg::OP_LINE;
        o_cmd.len   = mlf_pkg::CMD_LEN_W'(r_len);
        o_cmd.ovf   = r_ovf;
        if (work) begin
            case (r_mode)
                M_TOKEN: begin
                    if (is_digit) begin
                        consume = 1'b1;
                        if (r_cnt >= r_elen || idx[3] || r_etext[8*idx[2:0] +: 8] != b) begin
                            n_eq = 1'b0;
                        end
                        if (r_cnt != 4'd15) begin
                            n_cnt = r_cnt + 4'd1;
                        end
                    end else begin
                        if (r_een && r_eq && r_cnt == r_elen) begin
                            o_push   = 1'b1;
                            o_cmd.op = mlf_pkg::OP_MARK;
                        end
                        n_len = '0;
                        n_ovf = 1'b0;
                        n_cnt = 4'd0;
                        n_eq  = 1'b1;
                        if (b == mlf_pkg::CHAR_CR) begin
                            n_mode  = M_AFTER_CR;
                            consume = 1'b1;
                        end else begin
                            n_mode  = M_NORMAL;
                            consume = (b == mlf_pkg::CHAR_LF);
                        end
                    end
                end
                M_AFTER_CR: begin
                    // the byte is replayed in normal mode unless it is an LF
                    n_mode  = M_NORMAL;
                    consume = (b == mlf_pkg::CHAR_LF);
                end
                default: begin
                    consume = 1'b1;
                    n_win   = win_new;
                    if (hit) begin
                        if (!r_ovf) begin
                            n_len = (7'(r_len) > 7'(drop)) ? LEN_W'(7'(r_len) - 7'(drop)) : '0;
                        end
                        n_mode = M_TOKEN;
                        n_cnt  = 4'd0;
                        n_eq   = 1'b1;
                    end else if (b == mlf_pkg::CHAR_LF) begin
                        o_push = 1'b1;
                        n_len  = '0;
                        n_ovf  = 1'b0;
                    end else if (r_len < LEN_W'(LINE_DEPTH)) begin
                        o_ram_we = 1'b1;
                        n_len    = r_len + LEN_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            endcase
        end
    end

    assign i_in.ready = !r_slot_vld;

    always_ff @(posedge i_clk) begin
        if (i_in.valid && !r_slot_vld) begin
            r_slot_byte <= i_in.data_byte;
        end
        if (!i_rst_n) begin
            r_mtext    <= '0;
            r_mlen     <= 4'd0;
            r_etext    <= '0;
            r_elen     <= 4'd0;
            r_een      <= 1'b0;
            r_slot_vld <= 1'b0;
            r_busy     <= 1'b0;
            r_mode     <= M_NORMAL;
            r_len      <= '0;
            r_win      <= '0;
            r_cnt      <= 4'd0;
            r_eq       <= 1'b1;
            r_ovf      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mlf_pkg::CFG_MARKER_TEXT: r_mtext <= i_cfg_data[WIN_W-1:0];
                    mlf_pkg::CFG_MARKER_LEN:  r_mlen  <= i_cfg_data[3:0];
                    mlf_pkg::CFG_EXP_TEXT:    r_etext <= i_cfg_data;
                    mlf_pkg::CFG_EXP_LEN:     r_elen  <= i_cfg_data[3:0];
                    mlf_pkg::CFG_EXP_EN:      r_een   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in.valid && !r_slot_vld) begin
                r_slot_vld <= 1'b1;
            end else if (consume) begin
                r_slot_vld <= 1'b0;
            end
            if (o_push && r_len != '0) begin
                r_busy <= 1'b1;
            end else if (i_release) begin
                r_busy <= 1'b0;
            end
            r_mode <= n_mode;
            r_len  <= n_len;
            r_win  <= n_win;
            r_cnt  <= n_cnt;
            r_eq   <= n_eq;
            r_ovf  <= n_ovf;
        end
    end

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_ram_we)
        else $error("line store written while being drained");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(LINE_DEPTH))
        else $error("line length beyond store depth");

    a_busy_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && r_len != '0) |=> r_busy && r_len == '0)
        else $error("store not locked after emission command");

endmodule

// ----- rtl/core/mlf_back.sv -----
// Emitter: pops commands, drains the line store with trailing CR removal and
// drives the result register. Depends on mlf_pkg, mlf_out_if.
`timescale 1ns / 1ps

module mlf_back #(
    parameter int LINE_DEPTH = 63
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_vld,
    input  mlf_pkg::t_cmd                 i_cmd,
    output logic                          o_pop,
    output logic [$clog2(LINE_DEPTH)-1:0] o_ram_raddr,
    input  logic [7:0]                    i_ram_rdata,
    output logic                          o_release,
    mlf_out_if.source                     o_out
);

    localparam int LEN_W  = $clog2(LINE_DEPTH + 1);
    localparam int ADDR_W = $clog2(LINE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PK_W,
        S_PEEK,
        S_RD_W,
        S_LOAD,
        S_TAIL
    } t_state;

    t_state           r_state;
    mlf_pkg::t_op     r_op;
    logic             r_ovf;
    logic             r_hold;
    logic [LEN_W-1:0] r_n;
    logic [ADDR_W-1:0] r_addr;
    logic             r_release;
    logic             r_ovld;
    logic [1:0]       r_kind;
    logic [7:0]       r_byte;
    logic             r_last;
    logic             r_trunc;

    logic             free;
    logic             is_last;
    logic [LEN_W-1:0] cmd_len;

    assign free        = !r_ovld || o_out.ready;
    assign is_last     = (LEN_W'(r_addr) + LEN_W'(1)) == r_n;
    assign cmd_len     = LEN_W'(i_cmd.len);
    assign o_pop       = (r_state == S_IDLE) && i_q_vld;
    assign o_ram_raddr = r_addr;
    assign o_release   = r_release;

    assign o_out.valid      = r_ovld;
    assign o_out.kind       = r_kind;
    assign o_out.frame_byte = r_byte;
    assign o_out.frame_last = r_last;
    assign o_out.truncated  = r_trunc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_release <= 1'b0;
            r_ovld    <= 1'b0;
            r_hold    <= 1'b0;
            r_op      <= mlf_pkg::OP_LINE;
            r_ovf     <= 1'b0;
            r_n       <= '0;
            r_addr    <= '0;
        end else begin
            r_release <= 1'b0;
            if (r_ovld && o_out.ready) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_vld) begin
                        r_op   <= i_cmd.op;
                        r_ovf  <= i_cmd.ovf;
                        r_hold <= (cmd_len != '0);
                        r_n    <= cmd_len;
                        if (cmd_len == '0) begin
                            r_state <= S_TAIL;
                        end else if (i_cmd.ovf) begin
                            r_addr  <= '0;
                            r_state <= S_RD_W;
                        end else begin
                            r_addr  <= ADDR_W'(cmd_len - LEN_W'(1));
                            r_state <= S_PK_W;
                        end
                    end
                end
                S_PK_W: begin
                    r_state <= S_PEEK;
                end
                S_PEEK: begin
                    r_addr <= '0;
                    if (i_ram_rdata == mlf_pkg::CHAR_CR) begin
                        r_n     <= r_n - LEN_W'(1);
                        r_state <= (r_n == LEN_W'(1)) ? S_TAIL : S_RD_W;
                    end else begin
                        r_state <= S_RD_W;
                    end
                end
                S_RD_W: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (free) begin
                        r_ovld  <= 1'b1;
                        r_kind  <= mlf_pkg::KIND_BYTE;
                        r_byte  <= i_ram_rdata;
                        r_last  <= is_last;
                        r_trunc <= is_last && r_ovf;
                        if (is_last) begin
                            r_state <= S_TAIL;
                        end else begin
                            r_addr  <= r_addr + ADDR_W'(1);
                            r_state <= S_RD_W;
                        end
                    end
                end
                S_TAIL: begin
                    if (r_op == mlf_pkg::OP_MARK || r_n == '0) begin
                        if (free) begin
                            r_ovld    <= 1'b1;
                            r_kind    <= (r_op == mlf_pkg::OP_MARK) ? mlf_pkg::KIND_MARK
                                                                    : mlf_pkg::KIND_EMPTY;
                            r_byte    <= 8'd0;
                            r_last    <= (r_op == mlf_pkg::OP_LINE);
                            r_trunc   <= 1'b0;
                            r_release <= r_hold;
                            r_state   <= S_IDLE;
                        end
                    end else begin
                        r_release <= r_hold;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_load_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOAD |-> LEN_W'(r_addr) < r_n)
        else $error("store read past frame length");

    a_release_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_release |-> r_state == S_IDLE)
        else $error("store released while a frame is in flight");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_trunc) |-> r_last && r_kind == mlf_pkg::KIND_BYTE)
        else $error("truncated flag away from last frame byte");

endmodule

// ----- rtl/core/marker_line_framer.sv -----
// Marker line framer top level: classifier, command queue, line store, emitter.
// Depends on mlf_pkg, mlf_in_if, mlf_out_if, mlf_ram, mlf_cmd_q, mlf_front, mlf_back.
//
// Usage:
//   i_in carries one text byte per beat. o_out carries results: frame bytes
//   (kind 0, frame_last on the final byte), empty frames (kind 1) and
//   expected-marker events (kind 2). Registers are written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// Timing:
//   A byte is taken into a one-beat input slot and classified from there
//   once the classifier is free; the slot takes no new byte until then.
//   A newline or matched token hands the line to the emitter; the classifier then
//   holds further bytes, if the line is not empty, until the emitter has drained
//   the line store, which has one read port: a setup that may peek for a
//   trailing CR, then a read wait and a load per frame byte. A byte that ends
//   a token, or follows a token's CR, and is not swallowed is classified twice.
// Reset:
//   Synchronous, active low; clears registers, parse state and queue. The
//   line store needs no clearing pass.
// Stall:
//   Results wait in the output register; with o_out.ready low the emitter,
//   then the command queue and finally the input slot fill and hold.
`timescale 1ns / 1ps

module marker_line_framer #(
    parameter int LINE_DEPTH   = 63,
    parameter int MARKER_BYTES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mlf_in_if.sink                        i_in,
    mlf_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [mlf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                   i_cfg_data
);

    localparam int ADDR_W = $clog2(LINE_DEPTH);

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic              push;
    mlf_pkg::t_cmd     push_cmd;
    logic              q_full;
    logic              q_vld;
    mlf_pkg::t_cmd     q_cmd;
    logic              pop;
    logic              release_store;

    mlf_front #(
        .LINE_DEPTH   (LINE_DEPTH),
        .MARKER_BYTES (MARKER_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_q_full    (q_full),
        .i_release   (release_store)
    );

    mlf_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mlf_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    mlf_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_vld     (q_vld),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_release   (release_store),
        .o_out       (o_out)
    );

endmodule

// ----- dv/tb_marker_line_framer.sv -----
// Self-checking testbench for marker_line_framer: directed and random byte streams
// under random valid/ready gaps, checked against an in-bench line and marker predictor.
// Depends on mlf_pkg, mlf_in_if, mlf_out_if and the marker_line_framer RTL.
`timescale 1ns / 1ps

module tb_marker_line_framer;
    import mlf_pkg::*;

    localparam int STORE_DEPTH = 63;
    localparam int MARK_MAX    = 8;
    localparam int SETTLE      = 20;
    localparam int STALL_LIMIT = 3000;

    typedef enum logic [1:0] {
        SCAN_TEXT,
        SCAN_DIGITS,
        SCAN_AFTER_CR
    } scan_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic       trunc;
    } frame_result_t;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid  = 1'b0;
    logic [7:0]           in_data   = 8'h00;
    logic                 out_ready = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = CFG_MARKER_TEXT;
    logic [63:0]          cfg_data  = 64'd0;

    mlf_in_if  in_ch ();
    mlf_out_if out_ch ();

    assign in_ch.valid     = in_valid;
    assign in_ch.data_byte = in_data;
    assign out_ch.ready    = out_ready;

    marker_line_framer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register shadow
    logic [63:0] cfg_marker_text = 64'd0;
    logic [3:0]  cfg_marker_len  = 4'd0;
    logic [63:0] cfg_id_text     = 64'd0;
    logic [3:0]  cfg_id_len      = 4'd0;
    bit          cfg_expect      = 1'b0;

    // Framer state
    logic [7:0]  held_line [STORE_DEPTH];
    int          held_len      = 0;
    logic [63:0] recent_bytes  = 64'd0;
    scan_t       scan_state    = SCAN_TEXT;
    int          id_digits     = 0;
    bit          id_equal      = 1'b1;
    bit          held_overflow = 1'b0;

    logic [7:0]    pending_bytes [$];
    frame_result_t expected_results [$];
    logic [7:0]    gen_marker [$];
    logic [7:0]    gen_id [$];
    int            queued_total = 0;
    int            error_count  = 0;
    int            idle_cycles  = 0;
    int            send_wait    = 0;
    int            recv_wait    = 0;
    bit            send_calm    = 1'b0;
    bit            recv_calm    = 1'b0;

    function automatic void add_result(logic [1:0] k, logic [7:0] d, logic l, logic t);
        frame_result_t r;
        r.kind  = k;
        r.data  = d;
        r.last  = l;
        r.trunc = t;
        expected_results.push_back(r);
    endfunction

    // One trailing CR is dropped unless the line overflowed.
    function automatic int flush_line();
        int n;
        n = held_len;
        if (!held_overflow && n > 0 && held_line[n-1] == CHAR_CR) n--;
        for (int i = 0; i < n; i++) begin
            add_result(KIND_BYTE, held_line[i], i == n - 1, (i == n - 1) && held_overflow);
        end
        return n;
    endfunction

    function automatic bit marker_at_end();
        logic [63:0] mask;
        if (cfg_marker_len == 0 || cfg_marker_len > MARK_MAX) return 1'b0;
        if (!held_overflow && held_len + 1 < int'(cfg_marker_len)) return 1'b0;
        mask = (cfg_marker_len == 8) ? '1 : ((64'd1 << (8 * cfg_marker_len)) - 64'd1);
        return ((recent_bytes ^ cfg_marker_text) & mask) == 64'd0;
    endfunction

    function automatic void text_byte(logic [7:0] b);
        int drop;
        recent_bytes = {recent_bytes[55:0], b};
        if (marker_at_end()) begin
            drop = int'(cfg_marker_len) - 1;
            if (!held_overflow) held_len = (held_len > drop) ? held_len - drop : 0;
            scan_state = SCAN_DIGITS;
            id_digits  = 0;
            id_equal   = 1'b1;
            return;
        end
        if (b == CHAR_LF) begin
            if (flush_line() == 0) add_result(KIND_EMPTY, 8'h00, 1'b1, 1'b0);
            held_len      = 0;
            held_overflow = 1'b0;
            return;
        end
        if (held_len < STORE_DEPTH) held_line[held_len++] = b;
        else held_overflow = 1'b1;
    endfunction

    function automatic void digit_byte(logic [7:0] b);
        int idx;
        if (b >= CHAR_0 && b <= CHAR_9) begin
            if (id_digits >= int'(cfg_id_len)) begin
                id_equal = 1'b0;
            end else begin
                idx = int'(cfg_id_len) - 1 - id_digits;
                if (idx >= 8 || cfg_id_text[8*idx +: 8] != b) id_equal = 1'b0;
            end
            if (id_digits < 15) id_digits++;
            return;
        end
        if (cfg_expect && id_equal && id_digits == int'(cfg_id_len)) begin
            void'(flush_line());
            add_result(KIND_MARK, 8'h00, 1'b0, 1'b0);
        end
        held_len      = 0;
        held_overflow = 1'b0;
        id_digits     = 0;
        id_equal      = 1'b1;
        if (b == CHAR_CR) begin
            scan_state = SCAN_AFTER_CR;
        end else begin
            scan_state = SCAN_TEXT;
            if (b != CHAR_LF) text_byte(b);
        end
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        case (scan_state)
            SCAN_DIGITS: digit_byte(b);
            SCAN_AFTER_CR: begin
                scan_state = SCAN_TEXT;
                if (b != CHAR_LF) text_byte(b);
            end
            default: text_byte(b);
        endcase
    endfunction

    function automatic int gap_for(bit calm);
        return calm ? 0 : int'($urandom_range(0, 18));
    endfunction

    function automatic void queue_byte(logic [7:0] b);
        pending_bytes.push_back(b);
        queued_total++;
    endfunction

    function automatic void queue_text(string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endfunction

    function automatic logic [63:0] pack_text(string s);
        logic [63:0] v;
        v = 64'd0;
        for (int i = 0; i < s.len(); i++) v = {v[55:0], s[i]};
        return v;
    endfunction

    function automatic logic [7:0] any_text_char();
        return 8'($urandom_range(32, 126));
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b >= CHAR_0 && b <= CHAR_9);
        return b;
    endfunction

    task automatic drain();
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_MARKER_TEXT: cfg_marker_text = val;
            CFG_MARKER_LEN:  cfg_marker_len  = val[3:0];
            CFG_EXP_TEXT:    cfg_id_text     = val;
            CFG_EXP_LEN:     cfg_id_len      = val[3:0];
            CFG_EXP_EN:      cfg_expect      = val[0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setup(logic [63:0] mtext, logic [3:0] mlen, logic [63:0] itext,
                               logic [3:0] ilen, bit en);
        int k;
        drain();
        write_reg(CFG_MARKER_TEXT, mtext);
        write_reg(CFG_MARKER_LEN, 64'(mlen));
        write_reg(CFG_EXP_TEXT, itext);
        write_reg(CFG_EXP_LEN, 64'(ilen));
        write_reg(CFG_EXP_EN, 64'(en));
        gen_marker.delete();
        gen_id.delete();
        k = (mlen > 8) ? 8 : int'(mlen);
        for (int i = 0; i < k; i++) gen_marker.push_back(mtext[8*(k-1-i) +: 8]);
        k = (ilen > 8) ? 8 : int'(ilen);
        for (int i = 0; i < k; i++) gen_id.push_back(itext[8*(k-1-i) +: 8]);
    endtask

    // An overflowing line with a CR in the last store slot, closed either
    // by a token or by a newline.
    task automatic queue_long_line(bit with_token);
        repeat (STORE_DEPTH - 1) queue_byte(any_text_char());
        queue_byte(CHAR_CR);
        queue_byte(any_text_char());
        if (with_token) begin
            foreach (gen_marker[i]) queue_byte(gen_marker[i]);
            foreach (gen_id[i]) queue_byte(gen_id[i]);
        end
        queue_byte(CHAR_LF);
    endtask

    task automatic gen_traffic(int budget);
        int stop;
        int n;
        stop = queued_total + budget;
        while (queued_total < stop) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    repeat ($urandom_range(0, 10)) queue_byte(any_text_char());
                    if ($urandom_range(0, 1)) queue_byte(CHAR_CR);
                    queue_byte(CHAR_LF);
                end
                3, 4, 5, 6: begin
                    repeat ($urandom_range(0, 6)) queue_byte(any_text_char());
                    foreach (gen_marker[i]) queue_byte(gen_marker[i]);
                    case ($urandom_range(0, 3))
                        0, 1: foreach (gen_id[i]) queue_byte(gen_id[i]);
                        2: repeat ($urandom_range(0, 9))
                            queue_byte(8'($urandom_range(CHAR_0, CHAR_9)));
                        default: begin
                            foreach (gen_id[i]) queue_byte(gen_id[i]);
                            queue_byte(8'($urandom_range(CHAR_0, CHAR_9)));
                        end
                    endcase
                    case ($urandom_range(0, 4))
                        0: queue_byte(CHAR_CR);
                        1: queue_byte(CHAR_LF);
                        2: begin
                            queue_byte(CHAR_CR);
                            queue_byte(CHAR_LF);
                        end
                        3: begin
                            queue_byte(CHAR_CR);
                            queue_byte(any_text_char());
                        end
                        default: queue_byte(non_digit());
                    endcase
                end
                7: repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(0, 255)));
                8: begin
                    n = (gen_marker.size() > 1) ? $urandom_range(1, gen_marker.size() - 1) : 0;
                    for (int i = 0; i < n; i++) queue_byte(gen_marker[i]);
                    queue_byte(any_text_char());
                    queue_byte(CHAR_LF);
                end
                default: begin
                    if ($urandom_range(0, 1)) queue_byte(CHAR_CR);
                    queue_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
                    queue_byte(CHAR_LF);
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin : feed
        bit load;
        int gap;
        load = 1'b0;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ch.ready) begin
                predict_byte(in_data);
                if ($urandom_range(0, 23) == 0) send_calm <= !send_calm;
                gap = gap_for(send_calm);
                send_wait <= gap;
                load = (gap == 0);
            end else if (!in_valid) begin
                if (send_wait > 0) send_wait <= send_wait - 1;
                else load = 1'b1;
            end
            if (load && pending_bytes.size() != 0) begin
                in_valid <= 1'b1;
                in_data  <= pending_bytes.pop_front();
            end else if (in_valid && in_ch.ready) begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : collect
        frame_result_t want;
        int gap;
        if (rst_n) begin
            if (out_ch.valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected beat kind=%0d byte=%h last=%b trunc=%b",
                             $time, out_ch.kind, out_ch.frame_byte, out_ch.frame_last,
                             out_ch.truncated);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_ch.kind !== want.kind || out_ch.frame_byte !== want.data ||
                        out_ch.frame_last !== want.last || out_ch.truncated !== want.trunc) begin
                        $display("%0t: mismatch exp kind=%0d byte=%h last=%b trunc=%b",
                                 $time, want.kind, want.data, want.last, want.trunc);
                        $display("%0t:          got kind=%0d byte=%h last=%b trunc=%b",
                                 $time, out_ch.kind, out_ch.frame_byte, out_ch.frame_last,
                                 out_ch.truncated);
                        error_count++;
                    end
                end
                if ($urandom_range(0, 23) == 0) recv_calm <= !recv_calm;
                gap = gap_for(recv_calm);
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    recv_wait <= gap;
                end
            end else if (!out_ready) begin
                if (recv_wait <= 1) begin
                    out_ready <= 1'b1;
                    recv_wait <= 0;
                end else begin
                    recv_wait <= recv_wait - 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ch.ready) || (out_ch.valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;

        // detection off: plain, empty and CR-only lines, byte extremes
        queue_text("ab");
        queue_byte(CHAR_CR);
        queue_byte(CHAR_LF);
        queue_text("\n");
        queue_byte(CHAR_CR);
        queue_byte(CHAR_LF);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(CHAR_LF);

        apply_setup(pack_text("@M"), 4'd2, pack_text("42"), 4'd2, 1'b1);
        queue_text("x@M42\n");
        queue_text("@M7");
        queue_byte(CHAR_CR);
        queue_byte(CHAR_LF);
        queue_text("@M42");
        queue_byte(CHAR_CR);
        queue_text("q\n");
        queue_long_line(1'b1);

        apply_setup(pack_text("<<MARK>>"), 4'd8, pack_text("12345678"), 4'd8, 1'b1);
        gen_traffic(1);
        apply_setup(pack_text("#"), 4'd1, 64'd0, 4'd0, 1'b1);
        gen_traffic(6);
        apply_setup(pack_text("TAG"), 4'd9, pack_text("5"), 4'd1, 1'b1);
        gen_traffic(1);
        apply_setup(pack_text("ID:"), 4'd3, pack_text("7"), 4'd1, 1'b0);
        gen_traffic(1);
        apply_setup(pack_text("Z\n"), 4'd2, '1, 4'd15, 1'b1);
        gen_traffic(1);
        apply_setup('1, 4'd8, pack_text("9"), 4'd1, 1'b1);
        gen_traffic(1);

        drain();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
